// ----- hdl/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue cell array.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH     = 16;
   localparam int ELEM_BITS = 32;
   localparam int PRIO_BITS = 8;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   // command codes (tuser of the request channel)
   localparam logic [1:0] CMD_ENQ   = 2'd0;
   localparam logic [1:0] CMD_DEQ   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [ELEM_BITS-1:0] elem;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   // broadcast to every cell in the array
   typedef struct packed {
      logic      enq;      // insert new_entry (queue not full)
      logic      deq;      // shift toward head (queue not empty)
      entry_type new_entry;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ----- hdl/spq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array: holds an entry, compares it to the incoming
// priority and moves data toward its left or right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire logic         occupied,    // slot index below fill count
   input  wire logic         left_after,  // left neighbor yields to new entry
   input  wire entry_type    left_entry,
   input  wire entry_type    right_entry,
   output      logic         after,       // new entry goes at or before here
   output      entry_type    entry_q,
   output      entry_type    entry_next
);

   entry_type entry_ff;
   entry_type entry_in;

   // ties stay ahead of the new entry, so only strictly greater yields
   assign after = !occupied || (entry_ff.prio > ctl.new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.enq) begin
         if (after) begin
            entry_in = left_after ? left_entry : ctl.new_entry;
         end
      end else if (ctl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q    = entry_ff;
   assign entry_next = entry_in;

endmodule
`default_nettype wire

// ----- hdl/sorted_priority_queue_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded min-priority queue, FIFO among equal priorities, built as a row
// of compare-and-shift cells with the head in cell 0.
// ----------------------------------------------------------------------------
// Response: registered; the response beat appears in the cycle after the request beat is accepted.
// Throughput: 1 beat per cycle while the response side keeps rsp_tready high;
//   all cells compare and shift together in the cycle the command is
//   accepted.
// Reset: clears the fill count and the response valid; cell contents are not
//   cleared and are read only below the fill count.
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // [31:0] elem_value, [39:32] priority_req
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata    // [31:0] head_elem, [39:32] head_prio,
                                         // [44:40] count, [45] is_empty,
                                         // [47:46] status
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic [47:0]         rsp_data_ff, rsp_data_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   logic                accept;
   logic                is_full;
   logic                is_zero;
   logic [1:0]          status;
   cell_ctl_type        ctl;

   entry_type           cell_q    [DEPTH];
   entry_type           cell_next [DEPTH];
   logic                cell_after[DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_full = (count_ff == CNT_BITS'(DEPTH));
   assign is_zero = (count_ff == '0);

   always_comb begin
      ctl.enq                 = 1'b0;
      ctl.deq                 = 1'b0;
      ctl.new_entry.elem      = req_tdata[ELEM_BITS-1:0];
      ctl.new_entry.prio      = req_tdata[ELEM_BITS +: PRIO_BITS];
      status                  = ST_OK;
      count_in                = count_ff;
      if (accept) begin
         case (req_tuser)
            CMD_ENQ: begin
               if (is_full) begin
                  status = ST_FULL;
               end else begin
                  ctl.enq  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_DEQ: begin
               if (is_zero) begin
                  status = ST_EMPTY;
               end else begin
                  ctl.deq  = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               // query, and the unused code, leave the queue alone
            end
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      occupied;
      logic      left_after;
      entry_type left_entry;
      entry_type right_entry;

      assign occupied = (CNT_BITS'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_after = 1'b0;
         assign left_entry = ctl.new_entry;
      end else begin : g_body
         assign left_after = cell_after[i-1];
         assign left_entry = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_q[i];
      end else begin : g_mid
         assign right_entry = cell_q[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occupied),
         .left_after  (left_after),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .after       (cell_after[i]),
         .entry_q     (cell_q[i]),
         .entry_next  (cell_next[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (count_in == '0) begin
            rsp_data_in[31:0]  = '0;
            rsp_data_in[39:32] = '0;
         end else begin
            rsp_data_in[31:0]  = cell_next[0].elem;
            rsp_data_in[39:32] = cell_next[0].prio;
         end
         rsp_data_in[44:40] = 5'(count_in);
         rsp_data_in[45]    = (count_in == '0);
         rsp_data_in[47:46] = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("fill count above depth");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == CMD_ENQ && !is_full |=>
         count_ff == $past(count_ff) + 1'b1)
      else $error("accepted enqueue did not grow the queue");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[47:46] == ST_FULL |->
         rsp_data_ff[44:40] == 5'(DEPTH))
      else $error("full status reported on a queue that is not full");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[45] |->
         rsp_data_ff[39:0] == '0 && rsp_data_ff[44:40] == '0)
      else $error("empty beat carries a head or a count");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_priority_queue_core. Requests are driven with
// random gaps and the response side stalls at random. A scoreboard keeps its
// own sorted copy of the queue, predicts each response beat and compares it
// field by field. The directed part covers the empty, full and tie cases. The
// random part then swings the queue between full and empty.
// ----------------------------------------------------------------------------
module tb_top;
   import spq_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;   // unused code, behaves as query
   localparam int ITEM_TOTAL   = 800;
   localparam int QUIET_ITEMS  = 100;          // tail of the run with no idling
   localparam int STALL_LIMIT  = 1000;

   typedef struct packed {
      logic [1:0]           status;
      logic                 is_empty;
      logic [CNT_BITS-1:0]  count;
      logic [PRIO_BITS-1:0] head_prio;
      logic [ELEM_BITS-1:0] head_elem;
   } head_report_type;

   // tracks queue contents and the head reports still owed by the block
   class queue_tracker;
      logic [ELEM_BITS-1:0] slot_elem [DEPTH];
      logic [PRIO_BITS-1:0] slot_prio [DEPTH];
      int                   fill;
      head_report_type      owed_reports [$];
      int                   errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      function head_report_type apply_command(logic [1:0] cmd,
                                              logic [ELEM_BITS-1:0] elem,
                                              logic [PRIO_BITS-1:0] prio);
         head_report_type rep;
         int              pos;
         rep.status = ST_OK;
         case (cmd)
            CMD_ENQ: begin
               if (fill == DEPTH) begin
                  rep.status = ST_FULL;
               end else begin
                  // insert behind every entry of equal or smaller priority
                  pos = 0;
                  while (pos < fill && slot_prio[pos] <= prio) pos++;
                  for (int i = fill; i > pos; i--) begin
                     slot_elem[i] = slot_elem[i-1];
                     slot_prio[i] = slot_prio[i-1];
                  end
                  slot_elem[pos] = elem;
                  slot_prio[pos] = prio;
                  fill++;
               end
            end
            CMD_DEQ: begin
               if (fill == 0) begin
                  rep.status = ST_EMPTY;
               end else begin
                  for (int i = 0; i + 1 < fill; i++) begin
                     slot_elem[i] = slot_elem[i+1];
                     slot_prio[i] = slot_prio[i+1];
                  end
                  fill--;
               end
            end
            default: ;
         endcase
         rep.head_elem = (fill > 0) ? slot_elem[0] : '0;
         rep.head_prio = (fill > 0) ? slot_prio[0] : '0;
         rep.count     = CNT_BITS'(fill);
         rep.is_empty  = (fill == 0);
         return rep;
      endfunction

      function void note_request(logic [1:0] cmd, logic [ELEM_BITS-1:0] elem,
                                 logic [PRIO_BITS-1:0] prio);
         owed_reports.push_back(apply_command(cmd, elem, prio));
      endfunction

      function int pending();
         return owed_reports.size();
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [47:0] beat);
         head_report_type want;
         head_report_type got;
         got = head_report_type'(beat);
         if (owed_reports.size() == 0) begin
            $display("%0t: unexpected response beat: expected none actual %h", $time, beat);
            errors++;
            return;
         end
         want = owed_reports.pop_front();
         compare_field("head_elem", want.head_elem, got.head_elem);
         compare_field("head_prio", want.head_prio, got.head_prio);
         compare_field("count",     want.count,     got.count);
         compare_field("is_empty",  want.is_empty,  got.is_empty);
         compare_field("status",    want.status,    got.status);
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [31:0] elem_value, [39:32] priority_req
   logic [1:0]  req_tuser  = CMD_QUERY;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;   // [31:0] head_elem, [39:32] head_prio, [44:40] count,
                             // [45] is_empty, [47:46] status

   queue_tracker tracker = new();
   bit           no_idle = 1'b0;
   int           gap_pct = 25;
   int           idle_cycles = 0;

   sorted_priority_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("FAIL sorted_priority_queue_core");
      $finish;
   end

   // response side back-pressure
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         if (no_idle) begin
            @(posedge clock);
         end else begin
            repeat ($urandom_range(60, 1)) @(posedge clock);
            if (!no_idle) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(19, 1)) @(posedge clock);
            end
         end
      end
   end

   task automatic send_req(logic [1:0] cmd, logic [ELEM_BITS-1:0] elem,
                           logic [PRIO_BITS-1:0] prio);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {prio, elem};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(cmd, elem, prio);
      if (!no_idle && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
   endtask

   // hold off requests until every owed response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   initial begin
      int phase_left;
      int enq_pct;
      int query_pct;
      int prio_mode;
      int roll;
      logic [1:0]           cmd;
      logic [ELEM_BITS-1:0] elem;
      logic [PRIO_BITS-1:0] prio;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue: query, dequeue, spare code
      send_req(CMD_QUERY, 32'h1234_5678, 8'h5a);
      send_req(CMD_DEQ,   32'hffff_ffff, 8'hff);
      send_req(CMD_SPARE, 32'hdead_beef, 8'h81);
      // extremes and ties at both ends of the priority range
      send_req(CMD_ENQ,   32'hffff_ffff, 8'hff);
      send_req(CMD_ENQ,   32'h0000_0000, 8'h00);
      send_req(CMD_ENQ,   32'h0000_0001, 8'hff);
      send_req(CMD_ENQ,   32'h0000_0002, 8'h00);
      send_req(CMD_SPARE, 32'hffff_ffff, 8'hff);
      send_req(CMD_DEQ,   32'h0, 8'h0);
      // fill up, then overflow
      for (int i = 0; i < 14; i++)
         send_req(CMD_ENQ, 32'ha5a5_0000 | i, 8'((i * 37) % 256));
      send_req(CMD_ENQ,   32'h5a5a_5a5a, 8'h00);
      send_req(CMD_QUERY, 32'h0, 8'h0);
      wait_drained();

      phase_left = 0;
      enq_pct    = 50;
      query_pct  = 10;
      prio_mode  = 0;
      for (int n = 0; n < ITEM_TOTAL; n++) begin
         if (n == ITEM_TOTAL - QUIET_ITEMS) no_idle = 1'b1;
         if (phase_left == 0) begin
            phase_left = $urandom_range(60, 10);
            roll       = $urandom_range(2);
            enq_pct    = (roll == 0) ? 80 : (roll == 1) ? 15 : 45;
            query_pct  = $urandom_range(15, 3);
            prio_mode  = $urandom_range(2);
            roll       = $urandom_range(2);
            gap_pct    = (roll == 0) ? 0 : (roll == 1) ? 10 : 40;
            if (!no_idle && $urandom_range(7) == 0) wait_drained();
         end
         phase_left--;

         roll = $urandom_range(99);
         if (roll < query_pct)                cmd = $urandom_range(1) ? CMD_QUERY : CMD_SPARE;
         else if (roll < query_pct + enq_pct) cmd = CMD_ENQ;
         else                                 cmd = CMD_DEQ;

         case ($urandom_range(9))
            0:       elem = '0;
            1:       elem = '1;
            default: elem = $urandom;
         endcase
         case (prio_mode)
            0:       prio = $urandom_range(1) ? 8'($urandom_range(3))
                                              : 8'($urandom_range(255, 252));
            1:       prio = 8'($urandom_range(255));
            default: prio = $urandom_range(1) ? 8'h00 : 8'hff;
         endcase
         send_req(cmd, elem, prio);
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (5) @(posedge clock);
      if (tracker.errors == 0) $display("PASS sorted_priority_queue_core");
      else $display("FAIL sorted_priority_queue_core");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
tb/sv/tb_top.sv
